// ----- rtl/mps_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Mandelbrot pixel package
// Shared constants, types and arithmetic helpers for the smooth-colour
// escape-time pixel engine.
// ----------------------------------------------------------------------------
package mps_pkg;

  localparam int FRAC_BITS = 60;
  localparam int LOG_FB    = 28;
  localparam int V_FB      = 16;
  localparam int PAL_N     = 12;
  localparam int PAL_IW    = 4;
  localparam int COORD_W   = 13;
  localparam int NORM_W    = 45;
  localparam int NP_W      = 6;
  localparam int CNT_W     = 5;

  localparam int X_RES_DEF = 1706;
  localparam int Y_RES_DEF = 960;

  localparam logic [62:0] CENTER_RE_RST  = -63'sd857357701400000000;
  localparam logic [62:0] CENTER_IM_RST  = 63'sd151983640000000000;
  localparam logic [60:0] PIXEL_STEP_RST = 61'd4803839602528529;
  localparam logic [15:0] MAX_ITER_RST   = 16'd8000;

  localparam logic [7:0] PAL_R [PAL_N] = '{8'h00, 8'h40, 8'h7E, 8'h11, 8'h16, 8'h38,
                                           8'hFC, 8'hD0, 8'h5F, 8'hDC, 8'hFF, 8'h6B};
  localparam logic [7:0] PAL_G [PAL_N] = '{8'h00, 8'h40, 8'h9F, 8'h90, 8'h68, 8'hCF,
                                           8'hFF, 8'h99, 8'h00, 8'h37, 8'h8E, 8'h14};
  localparam logic [7:0] PAL_B [PAL_N] = '{8'h00, 8'hE0, 8'hFF, 8'h9F, 8'h18, 8'h3F,
                                           8'h00, 8'h24, 8'h09, 8'h0A, 8'hFE, 8'hBC};

  typedef enum logic [1:0] {
    CFG_CENTER_RE  = 2'd0,
    CFG_CENTER_IM  = 2'd1,
    CFG_PIXEL_STEP = 2'd2,
    CFG_MAX_ITER   = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    LOG_SRC_DIST = 2'd0,
    LOG_SRC_L1   = 2'd1,
    LOG_SRC_NORM = 2'd2
  } log_src_t;

  typedef struct packed {
    logic     capture;
    logic     coord_mul;
    logic     coord_add;
    logic     iter_mul;
    logic     iter_acc;
    logic     iter_upd;
    logic     log_load;
    log_src_t log_src;
    logic     log_step;
    logic     norm_load;
    logic     norm_step;
    logic     color;
  } mps_cmd_t;

  typedef struct packed {
    logic at_limit;
    logic esc_now;
    logic log_done;
    logic norm_done;
  } mps_stat_t;

  typedef logic [3:0][63:0] part4_t;

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sat_add64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sat_add64 = s[63:0];
    end
  endfunction

  function automatic logic [63:0] with_sign64(input logic [63:0] m, input logic neg);
    if (neg) begin
      with_sign64 = m[63] ? {1'b1, 63'd0} : 64'(64'd0 - m);
    end else begin
      with_sign64 = m[63] ? {1'b0, {63{1'b1}}} : m;
    end
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] v);
    mag64 = v[63] ? 64'(64'd0 - v) : v;
  endfunction

  function automatic part4_t part4(input logic [63:0] a, input logic [63:0] b);
    part4_t p;
    p[0] = 64'(a[31:0]) * 64'(b[31:0]);
    p[1] = 64'(a[31:0]) * 64'(b[63:32]);
    p[2] = 64'(a[63:32]) * 64'(b[31:0]);
    p[3] = 64'(a[63:32]) * 64'(b[63:32]);
    part4 = p;
  endfunction

  function automatic logic [127:0] join4(input part4_t p);
    join4 = {64'd0, p[0]} + {32'd0, p[1], 32'd0} + {32'd0, p[2], 32'd0} + {p[3], 64'd0};
  endfunction

  function automatic logic [PAL_IW-1:0] mod12(input logic [NP_W-1:0] v);
    logic [NP_W-1:0] t;
    t = v;
    for (int k = 0; k < 4; k++) begin
      if (t >= NP_W'(PAL_N)) begin
        t = t - NP_W'(PAL_N);
      end
    end
    mod12 = t[PAL_IW-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/mps_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Mandelbrot pixel controller
// Sequences coordinate mapping, orbit iteration, the logarithm chain and
// palette lookup for one pixel at a time.
// ----------------------------------------------------------------------------
module mps_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire mps_pkg::mps_stat_t stat,
  output mps_pkg::mps_cmd_t       cmd,
  output logic                    busy,
  output logic                    done
);

  typedef enum logic [16:0] {
    ST_IDLE  = 17'h00001,
    ST_CMUL  = 17'h00002,
    ST_CADD  = 17'h00004,
    ST_TEST  = 17'h00008,
    ST_MUL   = 17'h00010,
    ST_ACC   = 17'h00020,
    ST_UPD   = 17'h00040,
    ST_LD1   = 17'h00080,
    ST_LG1   = 17'h00100,
    ST_LD2   = 17'h00200,
    ST_LG2   = 17'h00400,
    ST_LDN   = 17'h00800,
    ST_NRM   = 17'h01000,
    ST_LD3   = 17'h02000,
    ST_LG3   = 17'h04000,
    ST_COLOR = 17'h08000,
    ST_DONE  = 17'h10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.log_src = mps_pkg::LOG_SRC_DIST;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_CMUL;
        end
      end
      ST_CMUL: begin
        cmd.coord_mul = 1'b1;
        state_nxt     = ST_CADD;
      end
      ST_CADD: begin
        cmd.coord_add = 1'b1;
        state_nxt     = ST_TEST;
      end
      ST_TEST: begin
        state_nxt = stat.at_limit ? ST_COLOR : ST_MUL;
      end
      ST_MUL: begin
        cmd.iter_mul = 1'b1;
        state_nxt    = ST_ACC;
      end
      ST_ACC: begin
        cmd.iter_acc = 1'b1;
        state_nxt    = ST_UPD;
      end
      ST_UPD: begin
        cmd.iter_upd = 1'b1;
        state_nxt    = stat.esc_now ? ST_LD1 : ST_TEST;
      end
      ST_LD1: begin
        cmd.log_load = 1'b1;
        cmd.log_src  = mps_pkg::LOG_SRC_DIST;
        state_nxt    = ST_LG1;
      end
      ST_LG1: begin
        if (stat.log_done) begin
          state_nxt = ST_LD2;
        end else begin
          cmd.log_step = 1'b1;
        end
      end
      ST_LD2: begin
        cmd.log_load = 1'b1;
        cmd.log_src  = mps_pkg::LOG_SRC_L1;
        state_nxt    = ST_LG2;
      end
      ST_LG2: begin
        if (stat.log_done) begin
          state_nxt = ST_LDN;
        end else begin
          cmd.log_step = 1'b1;
        end
      end
      ST_LDN: begin
        cmd.norm_load = 1'b1;
        state_nxt     = ST_NRM;
      end
      ST_NRM: begin
        if (stat.norm_done) begin
          state_nxt = ST_LD3;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      ST_LD3: begin
        cmd.log_load = 1'b1;
        cmd.log_src  = mps_pkg::LOG_SRC_NORM;
        state_nxt    = ST_LG3;
      end
      ST_LG3: begin
        if (stat.log_done) begin
          state_nxt = ST_COLOR;
        end else begin
          cmd.log_step = 1'b1;
        end
      end
      ST_COLOR: begin
        cmd.color = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);
  assign done = (state_r == ST_DONE);

endmodule
`default_nettype wire

// ----- rtl/mps_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Mandelbrot pixel datapath
// Coordinate mapping, Q4.60 orbit arithmetic, squaring log2 unit, normaliser
// and palette interpolation.
// ----------------------------------------------------------------------------
module mps_dp #(
  parameter int X_RES = mps_pkg::X_RES_DEF,
  parameter int Y_RES = mps_pkg::Y_RES_DEF
) (
  input  wire logic              clk,
  input  wire mps_pkg::mps_cmd_t cmd,
  output mps_pkg::mps_stat_t     stat,
  input  wire logic [10:0]       pixel_x,
  input  wire logic [9:0]        pixel_y,
  input  wire logic [62:0]       center_re,
  input  wire logic [62:0]       center_im,
  input  wire logic [60:0]       pixel_step,
  input  wire logic [15:0]       max_iter,
  output logic [7:0]             red,
  output logic [7:0]             green,
  output logic [7:0]             blue,
  output logic                   escaped,
  output logic [15:0]            iteration_count
);

  localparam int CW = mps_pkg::COORD_W;
  localparam logic [CW-1:0] HALF_X = CW'(X_RES / 2);
  localparam logic [CW-1:0] HALF_Y = CW'(Y_RES / 2);
  localparam int PW = 61 + CW;

  logic [10:0]    x_r;
  logic [9:0]     y_r;
  logic [PW-1:0]  offre_r, offim_r;
  logic           negre_r, negim_r;
  logic [63:0]    cre_r, cim_r, zr_r, zi_r;
  logic [15:0]    n_r;
  logic [mps_pkg::PAL_IW-1:0] nmod_r;
  logic           esc_r;
  mps_pkg::part4_t prr_r, pii_r, pri_r;
  logic [63:0]    r2_r, i2_r, cross_r, dist_r;
  logic [31:0]    m_r;
  logic [mps_pkg::LOG_FB-1:0] lr_r;
  logic [mps_pkg::CNT_W-1:0]  cnt_r;
  logic           int1_r;
  logic [mps_pkg::NORM_W-1:0] norm_r;
  logic [mps_pkg::NP_W-1:0]   np_r;
  logic [7:0]     red_r, green_r, blue_r;

  logic [CW-1:0]  dx, dy, mdx, mdy;
  logic [63:0]    offre_s, offim_s, mr, mi;
  logic [127:0]   prr, pii, pri;
  logic [64:0]    dsum;
  logic [63:0]    sq;
  logic [32:0]    sqt;
  logic [mps_pkg::NORM_W-1:0] arg_hi, arg_inner, arg;
  logic [mps_pkg::PAL_IW-1:0] pi, pj;
  logic [15:0]    fr;

  function automatic logic [7:0] interp(input logic [7:0] a, input logic [7:0] b,
                                        input logic [15:0] f);
    logic signed [8:0]  d;
    logic signed [25:0] acc;
    d   = $signed({1'b0, b}) - $signed({1'b0, a});
    acc = $signed({2'b00, a, 16'd0}) + d * $signed({1'b0, f});
    interp = acc[23:16];
  endfunction

  assign dx  = CW'({2'b00, x_r}) - HALF_X;
  assign dy  = CW'({3'b000, y_r}) - HALF_Y;
  assign mdx = dx[CW-1] ? CW'(-dx) : dx;
  assign mdy = dy[CW-1] ? CW'(-dy) : dy;

  assign offre_s = (|offre_r[PW-1:64]) ? '1 : offre_r[63:0];
  assign offim_s = (|offim_r[PW-1:64]) ? '1 : offim_r[63:0];

  assign mr = mps_pkg::mag64(zr_r);
  assign mi = mps_pkg::mag64(zi_r);

  assign prr = mps_pkg::join4(prr_r);
  assign pii = mps_pkg::join4(pii_r);
  assign pri = mps_pkg::join4(pri_r);

  assign dsum = {1'b0, r2_r} + {1'b0, i2_r};

  assign sq  = 64'(m_r) * 64'(m_r);
  assign sqt = sq[63:31];

  assign arg_hi    = {17'(n_r) + 17'd1, 28'd0};
  assign arg_inner = mps_pkg::NORM_W'(lr_r);
  assign arg       = (arg_hi > arg_inner) ? arg_hi - arg_inner : mps_pkg::NORM_W'(1);

  assign pi = esc_r ? mps_pkg::mod12(np_r + mps_pkg::NP_W'(8)) : nmod_r;
  assign pj = (pi == mps_pkg::PAL_IW'(mps_pkg::PAL_N - 1)) ? '0 : pi + 1'b1;
  assign fr = esc_r ? lr_r[15:0] : 16'd0;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r <= pixel_x;
      y_r <= pixel_y;
    end
    if (cmd.coord_mul) begin
      offre_r <= PW'(pixel_step) * PW'(mdx);
      offim_r <= PW'(pixel_step) * PW'(mdy);
      negre_r <= dx[CW-1];
      negim_r <= dy[CW-1];
    end
    if (cmd.coord_add) begin
      cre_r  <= mps_pkg::sat_add64({center_re[62], center_re},
                                   mps_pkg::with_sign64(offre_s, negre_r));
      cim_r  <= mps_pkg::sat_add64({center_im[62], center_im},
                                   mps_pkg::with_sign64(offim_s, negim_r));
      zr_r   <= mps_pkg::sat_add64({center_re[62], center_re},
                                   mps_pkg::with_sign64(offre_s, negre_r));
      zi_r   <= mps_pkg::sat_add64({center_im[62], center_im},
                                   mps_pkg::with_sign64(offim_s, negim_r));
      n_r    <= '0;
      nmod_r <= '0;
      esc_r  <= 1'b0;
    end
    if (cmd.iter_mul) begin
      prr_r <= mps_pkg::part4(mr, mr);
      pii_r <= mps_pkg::part4(mi, mi);
      pri_r <= mps_pkg::part4(mr, mi);
    end
    if (cmd.iter_acc) begin
      r2_r    <= (|prr[127:124]) ? '1 : prr[123:60];
      i2_r    <= (|pii[127:124]) ? '1 : pii[123:60];
      cross_r <= (|pri[127:123]) ? '1 : pri[122:59];
    end
    if (cmd.iter_upd) begin
      dist_r <= dsum[64] ? '1 : dsum[63:0];
      if (stat.esc_now) begin
        esc_r <= 1'b1;
      end else begin
        zi_r   <= mps_pkg::sat_add64(cim_r,
                    mps_pkg::with_sign64(cross_r, zr_r[63] ^ zi_r[63]));
        zr_r   <= mps_pkg::sat_add64(cre_r, 64'(r2_r - i2_r));
        n_r    <= n_r + 16'd1;
        nmod_r <= (nmod_r == mps_pkg::PAL_IW'(mps_pkg::PAL_N - 1)) ? '0 : nmod_r + 1'b1;
      end
    end
    if (cmd.log_load) begin
      lr_r <= '0;
      unique case (cmd.log_src)
        mps_pkg::LOG_SRC_DIST: begin
          m_r    <= dist_r[63] ? dist_r[63:32] : dist_r[62:31];
          int1_r <= dist_r[63];
          cnt_r  <= mps_pkg::CNT_W'(mps_pkg::LOG_FB);
        end
        mps_pkg::LOG_SRC_L1: begin
          m_r   <= {1'b1, int1_r, lr_r, 2'b00};
          cnt_r <= mps_pkg::CNT_W'(mps_pkg::LOG_FB);
        end
        mps_pkg::LOG_SRC_NORM: begin
          m_r   <= norm_r[mps_pkg::NORM_W-1 -: 32];
          cnt_r <= mps_pkg::CNT_W'(mps_pkg::V_FB);
        end
        default: begin
          m_r   <= norm_r[mps_pkg::NORM_W-1 -: 32];
          cnt_r <= '0;
        end
      endcase
    end
    if (cmd.log_step) begin
      lr_r  <= {lr_r[mps_pkg::LOG_FB-2:0], sqt[32]};
      m_r   <= sqt[32] ? sqt[32:1] : sqt[31:0];
      cnt_r <= cnt_r - 1'b1;
    end
    if (cmd.norm_load) begin
      norm_r <= arg;
      np_r   <= mps_pkg::NP_W'(mps_pkg::NORM_W - 1);
    end
    if (cmd.norm_step) begin
      norm_r <= {norm_r[mps_pkg::NORM_W-2:0], 1'b0};
      np_r   <= np_r - 1'b1;
    end
    if (cmd.color) begin
      red_r   <= interp(mps_pkg::PAL_R[pi], mps_pkg::PAL_R[pj], fr);
      green_r <= interp(mps_pkg::PAL_G[pi], mps_pkg::PAL_G[pj], fr);
      blue_r  <= interp(mps_pkg::PAL_B[pi], mps_pkg::PAL_B[pj], fr);
    end
  end

  assign stat.at_limit  = (n_r == max_iter);
  assign stat.esc_now   = dsum[64] | dsum[63] | dsum[62];
  assign stat.log_done  = (cnt_r == '0);
  assign stat.norm_done = norm_r[mps_pkg::NORM_W-1];

  assign red             = red_r;
  assign green           = green_r;
  assign blue            = blue_r;
  assign escaped         = esc_r;
  assign iteration_count = n_r;

endmodule
`default_nettype wire

// ----- rtl/mandelbrot_pixel_smooth_color.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Mandelbrot pixel with smooth colouring
// An interior point goes from accept to result through coordinate mapping and
// iteration; an escaped one also passes the logarithm chain and normaliser.
// Each iteration runs test, multiply, accumulate and update with 32x32 partial products.
// One pixel at a time: busy stays high until the result strobe.
// Synchronous reset returns to idle and loads the default view registers.
// ----------------------------------------------------------------------------
module mandelbrot_pixel_smooth_color #(
  parameter int X_RES = mps_pkg::X_RES_DEF,
  parameter int Y_RES = mps_pkg::Y_RES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [10:0] in_pixel_x,
  input  wire logic [9:0]  in_pixel_y,
  output logic             out_valid,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic             out_escaped,
  output logic [15:0]      out_iteration_count,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [62:0] cfg_wdata
);

  logic [62:0] center_re_r, center_im_r;
  logic [60:0] pixel_step_r;
  logic [15:0] max_iter_r;
  mps_pkg::mps_cmd_t  cmd;
  mps_pkg::mps_stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_re_r  <= mps_pkg::CENTER_RE_RST;
      center_im_r  <= mps_pkg::CENTER_IM_RST;
      pixel_step_r <= mps_pkg::PIXEL_STEP_RST;
      max_iter_r   <= mps_pkg::MAX_ITER_RST;
    end else if (cfg_we) begin
      unique case (mps_pkg::cfg_idx_t'(cfg_index))
        mps_pkg::CFG_CENTER_RE:  center_re_r  <= cfg_wdata;
        mps_pkg::CFG_CENTER_IM:  center_im_r  <= cfg_wdata;
        mps_pkg::CFG_PIXEL_STEP: pixel_step_r <= cfg_wdata[60:0];
        mps_pkg::CFG_MAX_ITER:   max_iter_r   <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  mps_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (out_valid)
  );

  mps_dp #(
    .X_RES (X_RES),
    .Y_RES (Y_RES)
  ) u_dp (
    .clk             (clk),
    .cmd             (cmd),
    .stat            (stat),
    .pixel_x         (in_pixel_x),
    .pixel_y         (in_pixel_y),
    .center_re       (center_re_r),
    .center_im       (center_im_r),
    .pixel_step      (pixel_step_r),
    .max_iter        (max_iter_r),
    .red             (out_red),
    .green           (out_green),
    .blue            (out_blue),
    .escaped         (out_escaped),
    .iteration_count (out_iteration_count)
  );

endmodule
`default_nettype wire

// ----- rtl/mps_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Mandelbrot pixel port checker
// Watches the command handshake and the result strobe on the top level.
// ----------------------------------------------------------------------------
module mps_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid
);

  a_word_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result word held for more than one cycle");

  a_word_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result word outside a busy period");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a start");

endmodule

bind mandelbrot_pixel_smooth_color mps_checker u_mps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
`default_nettype wire
